/* rtl/imsv_pkg.sv */
// Shared types and constants for the int8 scaled matrix-vector core.
// Used by imsv_front, imsv_row_fifo, imsv_scaler and int8_scaled_matvec_core.
package imsv_pkg;

   localparam int MAX_COLUMNS = 4096;
   localparam int STORE_AW    = $clog2(MAX_COLUMNS);

   localparam int INDEX_W   = 12;
   localparam int VALUE_W   = 32;
   localparam int WEIGHT_W  = 8;
   localparam int FP16_W    = 16;
   localparam int ROW_LEN_W = 13;
   localparam int PROD_W    = VALUE_W + WEIGHT_W;
   localparam int ACC_W     = 52;

   localparam int ROW_FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W     = $clog2(ROW_FIFO_DEPTH);
   localparam int FIFO_CNT_W     = $clog2(ROW_FIFO_DEPTH + 1);

   localparam int FRAC_W = 10;
   localparam int EXP_W  = 5;
   localparam int MANT_W = FRAC_W + 1;
   localparam int MAG_W  = ACC_W + MANT_W;
   localparam int ALIGN_W = MAG_W + 2;

   localparam logic [EXP_W-1:0] EXP_SPECIAL     = 5'd31;
   localparam logic [EXP_W-1:0] EXP_ZERO        = 5'd0;
   localparam logic [EXP_W-1:0] EXP_UNITY_SHIFT = 5'd25;
   localparam logic [EXP_W-1:0] SUBNORMAL_SHIFT = 5'd24;

   // Division by 127 folds seven-bit digits, since 128 is 127 plus one; seven
   // folds bring any 38-bit dividend to a residue of at most 127.
   localparam logic [7:0] SCALE_DIVISOR  = 8'd127;
   localparam int         FOLD_W         = 7;
   localparam int         DIV_W          = 38;
   localparam int         DIV_ITERATIONS = 7;
   localparam int         DIV_CNT_W      = $clog2(DIV_ITERATIONS);

   // Smallest aligned value whose quotient by 127 exceeds 2^31.
   localparam logic [ALIGN_W-1:0] SAT_LIMIT = 65'd272730423423;

   localparam logic [VALUE_W-1:0] Q_POS_CLAMP = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] Q_NEG_CLAMP = 32'h8000_0000;

   typedef struct packed {
      logic signed [ACC_W-1:0] row_sum;
      logic [FP16_W-1:0]       scale;
      logic                    last;
   } row_end_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
      logic                  empty;
   } fifo_status_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MUL,
      SC_ALIGN,
      SC_CHECK,
      SC_DIV,
      SC_FINISH,
      SC_EMIT
   } scaler_state_type;

endpackage

/* rtl/imsv_front.sv */
// Front end: input acceptance, vector store, column tracking and the
// multiply-accumulate pipeline. Depends on imsv_pkg.
module imsv_front
   import imsv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic                       req_action,
   input  logic [INDEX_W-1:0]         req_vec_index,
   input  logic signed [VALUE_W-1:0]  req_vec_value,
   input  logic signed [WEIGHT_W-1:0] req_weight,
   input  logic [FP16_W-1:0]          req_row_scale,
   input  logic                       req_end_of_matrix,
   input  logic                       csr_write_enable,
   input  logic [ROW_LEN_W-1:0]       csr_write_data,
   input  fifo_status_type            fifo_status,
   output logic                       row_push,
   output row_end_type                row_entry
);

   logic [VALUE_W-1:0] store_mem [MAX_COLUMNS];

   logic [ROW_LEN_W-1:0] row_len_ff;
   logic [ROW_LEN_W-1:0] col_ff, col_in;
   logic [FP16_W-1:0]    held_scale_ff, held_scale_in;

   logic                       s1_valid_ff, s1_end_ff, s1_last_ff;
   logic signed [WEIGHT_W-1:0] s1_weight_ff;
   logic [FP16_W-1:0]          s1_scale_ff;
   logic signed [VALUE_W-1:0]  rdata_ff;

   logic                     s2_valid_ff, s2_end_ff, s2_last_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [FP16_W-1:0]        s2_scale_ff;

   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_sum;

   logic                   accept, weight_accept, row_end;
   logic [ROW_LEN_W-1:0]   eff_len, col_plus;
   logic [FP16_W-1:0]      cur_scale;
   logic [FIFO_CNT_W:0]    occupancy;

   assign accept        = push && !full;
   assign weight_accept = accept && req_action;

   always_comb begin
      if (row_len_ff == '0) begin
         eff_len = ROW_LEN_W'(1);
      end else if (row_len_ff > ROW_LEN_W'(MAX_COLUMNS)) begin
         eff_len = ROW_LEN_W'(MAX_COLUMNS);
      end else begin
         eff_len = row_len_ff;
      end
   end

   assign col_plus  = col_ff + ROW_LEN_W'(1);
   assign row_end   = (col_plus >= eff_len) || req_end_of_matrix;
   assign cur_scale = (col_ff == '0) ? req_row_scale : held_scale_ff;

   always_comb begin
      col_in        = col_ff;
      held_scale_in = held_scale_ff;
      if (weight_accept) begin
         held_scale_in = cur_scale;
         col_in        = row_end ? '0 : col_plus;
      end
   end

   assign acc_sum = acc_ff + ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         acc_in = s2_end_ff ? '0 : acc_sum;
      end
   end

   assign row_push          = s2_valid_ff && s2_end_ff;
   assign row_entry.row_sum = acc_sum;
   assign row_entry.scale   = s2_scale_ff;
   assign row_entry.last    = s2_last_ff;

   // Row ends still in the pipeline hold a reserved place in the queue.
   assign occupancy = (FIFO_CNT_W + 1)'(fifo_status.count)
                    + (FIFO_CNT_W + 1)'(s1_end_ff)
                    + (FIFO_CNT_W + 1)'(s2_end_ff);
   assign full = occupancy >= (FIFO_CNT_W + 1)'(ROW_FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (accept && !req_action
          && ({1'b0, req_vec_index} < (INDEX_W + 1)'(MAX_COLUMNS))) begin
         store_mem[req_vec_index[STORE_AW-1:0]] <= req_vec_value;
      end
      if (weight_accept) begin
         rdata_ff <= $signed(store_mem[col_ff[STORE_AW-1:0]]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff    <= ROW_LEN_W'(MAX_COLUMNS);
         col_ff        <= '0;
         held_scale_ff <= '0;
         acc_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s1_end_ff     <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s2_end_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            row_len_ff <= csr_write_data;
         end
         col_ff        <= col_in;
         held_scale_ff <= held_scale_in;
         acc_ff        <= acc_in;
         s1_valid_ff   <= weight_accept;
         s1_end_ff     <= weight_accept && row_end;
         s2_valid_ff   <= s1_valid_ff;
         s2_end_ff     <= s1_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (weight_accept) begin
         s1_weight_ff <= req_weight;
         s1_scale_ff  <= cur_scale;
         s1_last_ff   <= req_end_of_matrix;
      end
      prod_ff     <= PROD_W'(s1_weight_ff) * PROD_W'(rdata_ff);
      s2_scale_ff <= s1_scale_ff;
      s2_last_ff  <= s1_last_ff;
   end

   a_col_in_store : assert property (@(posedge clock) disable iff (reset)
      col_ff < ROW_LEN_W'(MAX_COLUMNS))
      else $error("column count left the vector store");

   a_queue_credit : assert property (@(posedge clock) disable iff (reset)
      occupancy <= (FIFO_CNT_W + 1)'(ROW_FIFO_DEPTH))
      else $error("row ends in flight exceed the queue space");

endmodule

/* rtl/imsv_row_fifo.sv */
// Short queue of finished row sums between the front end and the scaler.
// Depends on imsv_pkg.
module imsv_row_fifo
   import imsv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_i,
   input  row_end_type     entry_i,
   input  logic            pop_i,
   output row_end_type     head_o,
   output fifo_status_type status_o
);

   row_end_type entry_ff [ROW_FIFO_DEPTH];

   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;

   assign head_o         = entry_ff[rd_ptr_ff];
   assign status_o.count = count_ff;
   assign status_o.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= entry_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_i) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop_i) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         case ({push_i, pop_i})
            2'b10:   count_ff <= count_ff + FIFO_CNT_W'(1);
            2'b01:   count_ff <= count_ff - FIFO_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push_i |-> (count_ff < FIFO_CNT_W'(ROW_FIFO_DEPTH)))
      else $error("row queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop_i |-> (count_ff != '0))
      else $error("row queue read while empty");

endmodule

/* rtl/imsv_scaler.sv */
// Back end: scales each finished row sum by its FP16 scale and 1/127,
// rounds, saturates and holds the result for the consumer. Depends on imsv_pkg.
module imsv_scaler
   import imsv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  fifo_status_type           fifo_status,
   input  row_end_type               fifo_head,
   output logic                      fifo_pop,
   input  logic                      pop,
   output logic                      empty,
   output logic signed [VALUE_W-1:0] rsp_row_value,
   output logic                      rsp_saturated,
   output logic                      rsp_last_row
);

   scaler_state_type state_ff, state_in;

   logic                 neg_ff, last_ff, ovf_ff;
   logic [ACC_W-1:0]     smag_ff;
   logic [EXP_W-1:0]     exp_ff;
   logic [FRAC_W-1:0]    frac_ff;
   logic [MAG_W-1:0]     mag_ff;
   logic [ALIGN_W-1:0]   v_ff;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [VALUE_W-1:0]   res_value_ff;
   logic                 res_sat_ff;

   logic               out_valid_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_sat_ff, out_last_ff;

   logic [MANT_W-1:0]  mant;
   logic               shift_up;
   logic [EXP_W-1:0]   amt;
   logic               direct;
   logic [VALUE_W-1:0] clamp_value;
   logic               out_load;
   logic [DIV_W-1:0]   fold_hi;
   logic [FOLD_W-1:0]  fold_lo;

   assign mant = (exp_ff == EXP_ZERO) ? {1'b0, frac_ff} : {1'b1, frac_ff};
   assign shift_up = exp_ff > EXP_UNITY_SHIFT;

   always_comb begin
      if (shift_up) begin
         amt = exp_ff - EXP_UNITY_SHIFT;
      end else if (exp_ff == EXP_ZERO) begin
         amt = SUBNORMAL_SHIFT;
      end else begin
         amt = EXP_UNITY_SHIFT - exp_ff;
      end
   end

   assign clamp_value = neg_ff ? Q_NEG_CLAMP : Q_POS_CLAMP;
   assign direct = (exp_ff == EXP_SPECIAL) || ovf_ff || (v_ff >= SAT_LIMIT);

   assign fold_hi = rem_ff >> FOLD_W;
   assign fold_lo = rem_ff[FOLD_W-1:0];

   always_comb begin
      if ((fold_hi == '0) && (fold_lo == FOLD_W'(SCALE_DIVISOR))) begin
         div_in = div_ff + DIV_W'(1);
         rem_in = '0;
      end else begin
         div_in = div_ff + fold_hi;
         rem_in = fold_hi + DIV_W'(fold_lo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      fifo_pop = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         SC_IDLE: begin
            if (!fifo_status.empty) begin
               fifo_pop = 1'b1;
               state_in = SC_MUL;
            end
         end
         SC_MUL:   state_in = SC_ALIGN;
         SC_ALIGN: state_in = SC_CHECK;
         SC_CHECK: state_in = direct ? SC_EMIT : SC_DIV;
         SC_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(DIV_ITERATIONS - 1)) begin
               state_in = SC_FINISH;
            end
         end
         SC_FINISH: state_in = SC_EMIT;
         SC_EMIT: begin
            if (!out_valid_ff || pop) begin
               out_load = 1'b1;
               state_in = SC_IDLE;
            end
         end
         default: state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         SC_IDLE: begin
            neg_ff  <= fifo_head.scale[FP16_W-1] ^ fifo_head.row_sum[ACC_W-1];
            smag_ff <= fifo_head.row_sum[ACC_W-1] ? $unsigned(-fifo_head.row_sum)
                                                  : $unsigned(fifo_head.row_sum);
            exp_ff  <= fifo_head.scale[FRAC_W +: EXP_W];
            frac_ff <= fifo_head.scale[FRAC_W-1:0];
            last_ff <= fifo_head.last;
         end
         SC_MUL: begin
            mag_ff <= MAG_W'(smag_ff) * MAG_W'(mant);
         end
         SC_ALIGN: begin
            if (shift_up) begin
               ovf_ff <= (mag_ff[MAG_W-1:40] != '0);
               v_ff   <= (ALIGN_W'(mag_ff) << amt) + ALIGN_W'(SCALE_DIVISOR >> 1);
            end else begin
               ovf_ff <= 1'b0;
               v_ff   <= ({1'b0, mag_ff, 1'b0} + (ALIGN_W'(SCALE_DIVISOR) << amt))
                         >> ({1'b0, amt} + 6'd1);
            end
         end
         SC_CHECK: begin
            div_ff     <= '0;
            rem_ff     <= v_ff[DIV_W-1:0];
            div_cnt_ff <= '0;
            res_sat_ff <= 1'b1;
            if ((exp_ff == EXP_SPECIAL) && ((frac_ff != '0) || (smag_ff == '0))) begin
               res_value_ff <= '0;
            end else begin
               res_value_ff <= clamp_value;
            end
         end
         SC_DIV: begin
            div_ff     <= div_in;
            rem_ff     <= rem_in;
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
         SC_FINISH: begin
            if (neg_ff) begin
               res_value_ff <= VALUE_W'(0) - div_ff[VALUE_W-1:0];
               res_sat_ff   <= 1'b0;
            end else if (div_ff > DIV_W'(Q_POS_CLAMP)) begin
               res_value_ff <= Q_POS_CLAMP;
               res_sat_ff   <= 1'b1;
            end else begin
               res_value_ff <= div_ff[VALUE_W-1:0];
               res_sat_ff   <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff <= res_value_ff;
         out_sat_ff   <= res_sat_ff;
         out_last_ff  <= last_ff;
      end
   end

   assign empty         = !out_valid_ff;
   assign rsp_row_value = $signed(out_value_ff);
   assign rsp_saturated = out_sat_ff;
   assign rsp_last_row  = out_last_ff;

   a_div_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SC_DIV) |-> (div_cnt_ff < DIV_CNT_W'(DIV_ITERATIONS)))
      else $error("divider ran past its last iteration");

endmodule

/* rtl/int8_scaled_matvec_core.sv */
// Top level of the int8 scaled matrix-vector core: front end, row queue and
// scaler. Depends on imsv_pkg, imsv_front, imsv_row_fifo and imsv_scaler.
//
// Usage. Items enter through a queue-like port: an item transfers when push
// is high and full is low. Action 0 writes one Q16.16 vector element; action
// 1 supplies one signed weight, row-major, with the row's FP16 scale sampled
// at column zero. The csr port sets the row length; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Each row produces one result, read like a queue: the result at the head
// is shown while empty is low and transfers when pop is high.
// Throughput: weights and vector writes are taken one per cycle while full
// is low. The scaler takes one row end at a time through idle, multiply,
// align, check, the digit-folding divide by 127, finish and emit; divide
// and finish are skipped when saturation is certain or the scale is Inf or
// NaN. The four-entry row queue absorbs bursts of short rows.
// When the consumer stalls, the output register holds the result, the scaler
// then the row queue fill, and full rises once the queue is taken up.
// Reset clears all control state, sets the row length to 4096 and empties
// the queue; the vector store is not cleared and must be written before use.
module int8_scaled_matvec_core
   import imsv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic                       req_action,
   input  logic [INDEX_W-1:0]         req_vec_index,
   input  logic signed [VALUE_W-1:0]  req_vec_value,
   input  logic signed [WEIGHT_W-1:0] req_weight,
   input  logic [FP16_W-1:0]          req_row_scale,
   input  logic                       req_end_of_matrix,
   input  logic                       pop,
   output logic                       empty,
   output logic signed [VALUE_W-1:0]  rsp_row_value,
   output logic                       rsp_saturated,
   output logic                       rsp_last_row,
   input  logic                       csr_write_enable,
   input  logic [ROW_LEN_W-1:0]       csr_write_data
);

   fifo_status_type fifo_status;
   row_end_type     row_entry, fifo_head;
   logic            row_push, fifo_pop;

   imsv_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_action        (req_action),
      .req_vec_index     (req_vec_index),
      .req_vec_value     (req_vec_value),
      .req_weight        (req_weight),
      .req_row_scale     (req_row_scale),
      .req_end_of_matrix (req_end_of_matrix),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .fifo_status       (fifo_status),
      .row_push          (row_push),
      .row_entry         (row_entry)
   );

   imsv_row_fifo u_row_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_i   (row_push),
      .entry_i  (row_entry),
      .pop_i    (fifo_pop),
      .head_o   (fifo_head),
      .status_o (fifo_status)
   );

   imsv_scaler u_scaler (
      .clock         (clock),
      .reset         (reset),
      .fifo_status   (fifo_status),
      .fifo_head     (fifo_head),
      .fifo_pop      (fifo_pop),
      .pop           (pop),
      .empty         (empty),
      .rsp_row_value (rsp_row_value),
      .rsp_saturated (rsp_saturated),
      .rsp_last_row  (rsp_last_row)
   );

endmodule
